@@ src/pd_line_follower_step_defines.svh @@
// Assertion macros for the PD line follower step block.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef PD_LINE_FOLLOWER_STEP_DEFINES_SVH
`define PD_LINE_FOLLOWER_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define PDLF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PDLF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDLF_ASSERT_IMP(lbl, ante, cons, msg)
`define PDLF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/pdlf_pkg.sv @@
// Shared types, widths and codes for the PD line follower step block.
// No dependencies.
package pdlf_pkg;

    localparam int unsigned SENSOR_COUNT = 8;
    localparam int unsigned SAMPLE_W     = 10;
    localparam int unsigned POS_W        = 13;
    localparam int unsigned CNT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int unsigned BCOUNT_W     = 4;
    localparam int unsigned ACTION_W     = 2;
    localparam int unsigned GAIN_W       = 10;
    localparam int unsigned DUTY_W       = 8;
    localparam int unsigned ERR_W        = 14;
    localparam int unsigned DIFF_W       = 15;
    localparam int unsigned P_W          = 25;
    localparam int unsigned D_W          = 26;
    localparam int unsigned SUM_W        = 27;
    localparam int unsigned FRAC_W       = 8;
    localparam int unsigned CORR_W       = SUM_W - FRAC_W;
    localparam int unsigned SPEED_W      = CORR_W + 1;

    localparam int unsigned S_TDATA_RAW  = SENSOR_COUNT * SAMPLE_W + POS_W;
    localparam int unsigned S_TDATA_W    = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W    = 24;

    localparam int unsigned APB_ADDR_W   = 5;
    localparam int unsigned APB_DATA_W   = 32;

    localparam int unsigned VICTORY_ABOVE = 4;
    localparam int unsigned STOP_AT       = 4;
    localparam int unsigned PD_AT         = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HOLD    = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_VICTORY = 2'd2,
        ACT_DRIVE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_THRESH = 3'd0,
        REG_CENTER = 3'd1,
        REG_BASE   = 3'd2,
        REG_KP     = 3'd3,
        REG_KD     = 3'd4,
        REG_LMAX   = 3'd5,
        REG_RMAX   = 3'd6,
        REG_NONE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_action          action;
        logic [CNT_W-1:0] count;
    } t_merge_res;

    typedef struct packed {
        logic              rev;
        logic [DUTY_W-1:0] duty;
    } t_motor;

endpackage

@@ src/pd_line_follower_step.sv @@
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         sensor_0..7 (10b each), line_position (13b)
// m_axis    out  tvalid/tready         action, black_count, left/right reverse+duty
// apb       in   psel/penable/pwrite   7 config registers at 4*index
//
// One item per cycle sustained while m_axis is not stalled; each result passes through the
// lane compare/merge, gain multiply, correction and drive/output registers in turn.
// previous_error updates at acceptance of a PD item, so back-to-back PD items see it at once.
// Synchronous active-low reset clears valids and previous_error and loads config defaults.
// Each stage loads when empty or when the next one moves, so bubbles close
// while m_axis is stalled; input stalls only with all four stages full.
//
// Top level of the PD line follower step block.
// Depends on pdlf_pkg, pdlf_lane, pdlf_merge, pdlf_drive and the defines header.
`include "pd_line_follower_step_defines.svh"

module pd_line_follower_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] sensor_0 ... [79:70] sensor_7, [92:80] line_position, [95:93] zero
    input  logic [pdlf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] action, [5:2] black_count, [6] left_reverse, [14:7] left_duty,
    // [15] right_reverse, [23:16] right_duty
    output logic [pdlf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // APB config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdlf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pdlf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pdlf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // ---------------- configuration registers ----------------
    logic [pdlf_pkg::SAMPLE_W-1:0] r_thresh;
    logic [pdlf_pkg::POS_W-1:0]    r_center;
    logic [pdlf_pkg::DUTY_W-1:0]   r_base;
    logic [pdlf_pkg::GAIN_W-1:0]   r_kp;
    logic [pdlf_pkg::GAIN_W-1:0]   r_kd;
    logic [pdlf_pkg::DUTY_W-1:0]   r_lmax;
    logic [pdlf_pkg::DUTY_W-1:0]   r_rmax;

    pdlf_pkg::t_reg_idx w_reg_idx;
    logic               w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = pdlf_pkg::t_reg_idx'(paddr[pdlf_pkg::APB_ADDR_W-1:2]);
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= pdlf_pkg::SAMPLE_W'(600);
            r_center <= pdlf_pkg::POS_W'(3500);
            r_base   <= pdlf_pkg::DUTY_W'(150);
            r_kp     <= pdlf_pkg::GAIN_W'(128);
            r_kd     <= pdlf_pkg::GAIN_W'(512);
            r_lmax   <= pdlf_pkg::DUTY_W'(245);
            r_rmax   <= pdlf_pkg::DUTY_W'(255);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                pdlf_pkg::REG_THRESH: r_thresh <= pwdata[pdlf_pkg::SAMPLE_W-1:0];
                pdlf_pkg::REG_CENTER: r_center <= pwdata[pdlf_pkg::POS_W-1:0];
                pdlf_pkg::REG_BASE:   r_base   <= pwdata[pdlf_pkg::DUTY_W-1:0];
                pdlf_pkg::REG_KP:     r_kp     <= pwdata[pdlf_pkg::GAIN_W-1:0];
                pdlf_pkg::REG_KD:     r_kd     <= pwdata[pdlf_pkg::GAIN_W-1:0];
                pdlf_pkg::REG_LMAX:   r_lmax   <= pwdata[pdlf_pkg::DUTY_W-1:0];
                pdlf_pkg::REG_RMAX:   r_rmax   <= pwdata[pdlf_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            pdlf_pkg::REG_THRESH: prdata = pdlf_pkg::APB_DATA_W'(r_thresh);
            pdlf_pkg::REG_CENTER: prdata = pdlf_pkg::APB_DATA_W'(r_center);
            pdlf_pkg::REG_BASE:   prdata = pdlf_pkg::APB_DATA_W'(r_base);
            pdlf_pkg::REG_KP:     prdata = pdlf_pkg::APB_DATA_W'(r_kp);
            pdlf_pkg::REG_KD:     prdata = pdlf_pkg::APB_DATA_W'(r_kd);
            pdlf_pkg::REG_LMAX:   prdata = pdlf_pkg::APB_DATA_W'(r_lmax);
            pdlf_pkg::REG_RMAX:   prdata = pdlf_pkg::APB_DATA_W'(r_rmax);
            default:              prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic r_v0, r_v1, r_v2, r_v3;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3;
    logic w_acc;

    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign w_rdy0        = !r_v0 || w_rdy1;
    assign s_axis_tready = w_rdy0;
    assign w_acc         = s_axis_tvalid && w_rdy0;
    assign m_axis_tvalid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= s_axis_tvalid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 0: lanes, merge, error ----------------
    logic [pdlf_pkg::SENSOR_COUNT-1:0] w_black;
    pdlf_pkg::t_merge_res              w_merge;

    for (genvar g = 0; g < pdlf_pkg::SENSOR_COUNT; g++) begin : g_lane
        pdlf_lane u_lane (
            .i_sample    (s_axis_tdata[g*pdlf_pkg::SAMPLE_W +: pdlf_pkg::SAMPLE_W]),
            .i_threshold (r_thresh),
            .o_black     (w_black[g])
        );
    end

    pdlf_merge u_merge (
        .i_black (w_black),
        .o_res   (w_merge)
    );

    logic        [pdlf_pkg::POS_W-1:0]  w_pos;
    logic signed [pdlf_pkg::ERR_W-1:0]  w_err;
    logic signed [pdlf_pkg::DIFF_W-1:0] w_diff;
    logic signed [pdlf_pkg::ERR_W-1:0]  r_prev_err;

    assign w_pos  = s_axis_tdata[pdlf_pkg::SENSOR_COUNT*pdlf_pkg::SAMPLE_W +: pdlf_pkg::POS_W];
    assign w_err  = $signed({1'b0, w_pos}) - $signed({1'b0, r_center});
    assign w_diff = pdlf_pkg::DIFF_W'(w_err) - pdlf_pkg::DIFF_W'(r_prev_err);

    // previous error moves only on an accepted PD transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (w_acc && w_merge.action == pdlf_pkg::ACT_DRIVE) begin
            r_prev_err <= w_err;
        end
    end

    pdlf_pkg::t_action                  r_act0;
    logic        [pdlf_pkg::CNT_W-1:0]  r_cnt0;
    logic signed [pdlf_pkg::ERR_W-1:0]  r_err0;
    logic signed [pdlf_pkg::DIFF_W-1:0] r_diff0;

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_act0  <= w_merge.action;
            r_cnt0  <= w_merge.count;
            r_err0  <= w_err;
            r_diff0 <= w_diff;
        end
    end

    // ---------------- stage 1: gain multiplies ----------------
    pdlf_pkg::t_action                 r_act1;
    logic        [pdlf_pkg::CNT_W-1:0] r_cnt1;
    logic signed [pdlf_pkg::P_W-1:0]   r_p1;
    logic signed [pdlf_pkg::D_W-1:0]   r_d1;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_act1 <= r_act0;
            r_cnt1 <= r_cnt0;
            r_p1   <= pdlf_pkg::P_W'($signed({1'b0, r_kp})) * pdlf_pkg::P_W'(r_err0);
            r_d1   <= pdlf_pkg::D_W'($signed({1'b0, r_kd})) * pdlf_pkg::D_W'(r_diff0);
        end
    end

    // ---------------- stage 2: sum, divide by 256 toward zero ----------------
    logic signed [pdlf_pkg::SUM_W-1:0] w_sum;
    logic signed [pdlf_pkg::SUM_W-1:0] w_biased;

    assign w_sum    = pdlf_pkg::SUM_W'(r_p1) + pdlf_pkg::SUM_W'(r_d1);
    // negative sums get 255 added so the arithmetic shift rounds toward zero
    assign w_biased = w_sum + (w_sum[pdlf_pkg::SUM_W-1] ?
                      pdlf_pkg::SUM_W'((1 << pdlf_pkg::FRAC_W) - 1) : pdlf_pkg::SUM_W'(0));

    pdlf_pkg::t_action                  r_act2;
    logic        [pdlf_pkg::CNT_W-1:0]  r_cnt2;
    logic signed [pdlf_pkg::CORR_W-1:0] r_corr2;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_act2  <= r_act1;
            r_cnt2  <= r_cnt1;
            r_corr2 <= w_biased[pdlf_pkg::SUM_W-1:pdlf_pkg::FRAC_W];
        end
    end

    // ---------------- stage 3: motor drive, output register ----------------
    logic signed [pdlf_pkg::SPEED_W-1:0] w_lspeed;
    logic signed [pdlf_pkg::SPEED_W-1:0] w_rspeed;
    pdlf_pkg::t_motor                    w_lmotor;
    pdlf_pkg::t_motor                    w_rmotor;

    assign w_lspeed = pdlf_pkg::SPEED_W'($signed({2'b00, r_base}))
                    + pdlf_pkg::SPEED_W'(r_corr2);
    assign w_rspeed = pdlf_pkg::SPEED_W'($signed({2'b00, r_base}))
                    - pdlf_pkg::SPEED_W'(r_corr2);

    pdlf_drive u_drive_l (
        .i_speed (w_lspeed),
        .i_limit (r_lmax),
        .o_motor (w_lmotor)
    );

    pdlf_drive u_drive_r (
        .i_speed (w_rspeed),
        .i_limit (r_rmax),
        .o_motor (w_rmotor)
    );

    pdlf_pkg::t_action                 r_act3;
    logic        [pdlf_pkg::CNT_W-1:0] r_cnt3;
    pdlf_pkg::t_motor                  r_lmotor;
    pdlf_pkg::t_motor                  r_rmotor;

    // motor fields read zero for hold, stop and victory
    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_act3 <= r_act2;
            r_cnt3 <= r_cnt2;
            if (r_act2 == pdlf_pkg::ACT_DRIVE) begin
                r_lmotor <= w_lmotor;
                r_rmotor <= w_rmotor;
            end else begin
                r_lmotor <= '0;
                r_rmotor <= '0;
            end
        end
    end

    assign m_axis_tdata = {r_rmotor.duty, r_rmotor.rev, r_lmotor.duty, r_lmotor.rev,
                           pdlf_pkg::BCOUNT_W'(r_cnt3), r_act3};

    // ---------------- assertions ----------------
    `PDLF_ASSERT_IMP(a_duty_limit,
        m_axis_tvalid && r_act3 == pdlf_pkg::ACT_DRIVE,
        r_lmotor.duty <= r_lmax && r_rmotor.duty <= r_rmax,
        "duty above its limit")
    `PDLF_ASSERT_IMP(a_idle_motors,
        m_axis_tvalid && r_act3 != pdlf_pkg::ACT_DRIVE,
        r_lmotor == '0 && r_rmotor == '0,
        "motor fields nonzero without PD drive")
    `PDLF_ASSERT_NXT(a_prev_hold,
        !(w_acc && w_merge.action == pdlf_pkg::ACT_DRIVE),
        $stable(r_prev_err),
        "previous error moved without a PD transaction")
    `PDLF_ASSERT_IMP(a_drive_count,
        r_v0 && r_act0 == pdlf_pkg::ACT_DRIVE,
        r_cnt0 == pdlf_pkg::PD_AT,
        "PD drive with wrong black count")

endmodule

@@ src/pdlf_lane.sv @@
// One sensor lane: threshold compare of a single reflectance sample.
// Depends on pdlf_pkg.
module pdlf_lane (
    input  logic [pdlf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [pdlf_pkg::SAMPLE_W-1:0] i_threshold,
    output logic                          o_black
);

    // strictly above threshold sees black
    assign o_black = (i_sample > i_threshold);

endmodule

@@ src/pdlf_merge.sv @@
// Merge stage: counts the lane hits and picks the action.
// Depends on pdlf_pkg.
module pdlf_merge (
    input  logic [pdlf_pkg::SENSOR_COUNT-1:0] i_black,
    output pdlf_pkg::t_merge_res              o_res
);

    logic [pdlf_pkg::CNT_W-1:0] w_count;

    always_comb begin
        w_count = '0;
        for (int i = 0; i < pdlf_pkg::SENSOR_COUNT; i++) begin
            w_count = w_count + pdlf_pkg::CNT_W'(i_black[i]);
        end
    end

    always_comb begin
        o_res.count = w_count;
        if (w_count > pdlf_pkg::VICTORY_ABOVE) begin
            o_res.action = pdlf_pkg::ACT_VICTORY;
        end else if (w_count == pdlf_pkg::STOP_AT) begin
            o_res.action = pdlf_pkg::ACT_STOP;
        end else if (w_count == pdlf_pkg::PD_AT) begin
            o_res.action = pdlf_pkg::ACT_DRIVE;
        end else begin
            o_res.action = pdlf_pkg::ACT_HOLD;
        end
    end

endmodule

@@ src/pdlf_drive.sv @@
// Motor drive: splits a signed speed into direction and saturated duty.
// Depends on pdlf_pkg.
module pdlf_drive (
    input  logic signed [pdlf_pkg::SPEED_W-1:0] i_speed,
    input  logic        [pdlf_pkg::DUTY_W-1:0]  i_limit,
    output pdlf_pkg::t_motor                    o_motor
);

    logic [pdlf_pkg::SPEED_W-1:0] w_mag;

    always_comb begin
        o_motor.rev = i_speed[pdlf_pkg::SPEED_W-1];
        w_mag = o_motor.rev ? pdlf_pkg::SPEED_W'(-i_speed) : pdlf_pkg::SPEED_W'(i_speed);
        if (w_mag > pdlf_pkg::SPEED_W'(i_limit)) begin
            o_motor.duty = i_limit;
        end else begin
            o_motor.duty = w_mag[pdlf_pkg::DUTY_W-1:0];
        end
    end

endmodule
